// ===== rtl/core/ecgrpw_pkg.sv =====
// Package: shared constants and types for the R-peak window detector
`default_nettype none
package ecgrpw_pkg;
  localparam int WinSize     = 64;
  localparam int RightMargin = 7;
  localparam int IdxW        = $clog2(WinSize);
  localparam int CntW        = $clog2(WinSize + 1);
  localparam int SampW       = 24;
  localparam int NumW        = 32;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;
  localparam int EntryW      = 2 * SampW + NumW + 1;

  localparam logic [CfgIdxW-1:0] RegRise     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidthMin = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidthMax = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHoldoff  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRefill   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAsys     = 3'd6;

  localparam logic [15:0] SinceMax = 16'hFFFF;

  typedef struct packed {
    logic signed [SampW-1:0] ecg_sample;
    logic signed [SampW-1:0] baseline_value;
    logic [NumW-1:0]         sample_number;
  } in_item_t;

  typedef struct packed {
    logic signed [SampW-1:0] oldest_sample;
    logic signed [SampW-1:0] oldest_baseline;
    logic                    oldest_is_peak;
    logic                    beat_detected;
    logic [NumW-1:0]         rr_interval_ms;
    logic                    asystole_event;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/ecgrpw_if.sv =====
// Interface: valid/ready channel carrying one payload beat
`default_nettype none
interface ecgrpw_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ecg_r_peak_window_detector.sv =====
// Top level: R-peak window detector with circular window RAM and scan sequencer
// A full check walks the window up to three times through the single RAM read port.
// Throughput: one item at a time; input ready only while the sequencer is idle and no result waits.
// Window RAM is cleared after reset by a pass over every slot, no item accepted
//   meanwhile; configuration writes are taken at any time.
`default_nettype none
module ecg_r_peak_window_detector (
  input wire logic clk,
  input wire logic rst_n,
  ecgrpw_if.sink   in_ch,
  ecgrpw_if.source out_ch,
  ecgrpw_if.sink   cfg_ch
);
  import ecgrpw_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_HOLD, S_RISE, S_DROP, S_MAX, S_MARK, S_OLD, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [SampW-1:0] s;
    logic signed [SampW-1:0] b;
    logic [NumW-1:0]         n;
    logic                    p;
  } entry_t;

  state_t state_r;
  logic [23:0] rise_r, height_r;
  logic [5:0]  wmin_r, wmax_r;
  logic [15:0] holdoff_r, asys_lim_r;
  logic [6:0]  def_refill_r;

  logic [IdxW-1:0] head_r;          // physical slot of logical slot 0
  logic [CntW-1:0] fill_r, target_r;
  logic            ready_win_r, hold_act_r, asys_flag_r;
  logic [NumW-1:0] hold_org_r, last_pk_r;
  logic [15:0]     since_r;

  logic [IdxW:0]   scan_r;          // logical slot being issued
  logic            rv_r;            // read data valid for scan_r-1
  logic [IdxW-1:0] rd_idx_r;        // logical index of data in rdata
  logic [IdxW-1:0] start_r, finish_r, maxi_r;
  logic signed [SampW-1:0] base_r, amp_r;
  logic [NumW-1:0] pn_r;
  out_item_t       out_r;
  logic            out_v_r;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;

  ecgrpw_ram #(.Width(EntryW), .Depth(WinSize)) u_win (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // logical to physical addressing
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] h, input logic [IdxW-1:0] l);
    return h + l;
  endfunction

  localparam logic [IdxW:0] ScanRiseEnd = (IdxW+1)'(WinSize - RightMargin);
  localparam logic [IdxW:0] ScanEnd     = (IdxW+1)'(WinSize);

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  logic signed [SampW:0] excess;
  logic [6:0] len;
  logic signed [SampW:0] height;
  always_comb begin
    excess = {rdata.s[SampW-1], rdata.s} - {rdata.b[SampW-1], rdata.b};
    len    = {1'b0, rd_idx_r} - {1'b0, start_r};
    height = {amp_r[SampW-1], amp_r} - {base_r[SampW-1], base_r};
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = head_r;
    wdata = '0;
    raddr = phys(head_r, scan_r[IdxW-1:0]);
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = scan_r[IdxW-1:0];
      end
      S_IDLE: begin
        // accepted beat lands in the oldest slot, which becomes the newest
        we    = in_ch.valid && in_ch.ready;
        waddr = head_r;
        wdata.s = in_ch.data.ecg_sample;
        wdata.b = in_ch.data.baseline_value;
        wdata.n = in_ch.data.sample_number;
        wdata.p = 1'b0;
      end
      S_MARK: begin
        // write back once the peak slot has been read
        we    = rv_r;
        waddr = phys(head_r, maxi_r);
        wdata = rdata;
        wdata.p = 1'b1;
      end
      S_HOLD, S_OLD: raddr = head_r;
      S_MAX:  raddr = phys(head_r, scan_r[IdxW-1:0]);
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= 24'd300; height_r <= 24'd8000; wmin_r <= 6'd3; wmax_r <= 6'd30;
      holdoff_r <= 16'd50; def_refill_r <= 7'd32; asys_lim_r <= 16'd1000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        RegRise:     rise_r       <= cfg_ch.data.data[23:0];
        RegHeight:   height_r     <= cfg_ch.data.data[23:0];
        RegWidthMin: wmin_r       <= cfg_ch.data.data[5:0];
        RegWidthMax: wmax_r       <= cfg_ch.data.data[5:0];
        RegHoldoff:  holdoff_r    <= cfg_ch.data.data[15:0];
        RegRefill:   def_refill_r <= cfg_ch.data.data[6:0];
        RegAsys:     asys_lim_r   <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; scan_r <= '0; head_r <= '0; fill_r <= '0;
      target_r <= CntW'(7'd32); ready_win_r <= 1'b0; hold_act_r <= 1'b0;
      hold_org_r <= '0; last_pk_r <= '0; since_r <= '0; asys_flag_r <= 1'b0;
      out_v_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      if (out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == ScanEnd - 1'b1) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && !out_v_r) state_r <= S_WRITE;
        S_WRITE: begin
          head_r <= head_r + 1'b1;
          out_r  <= '0;
          if (since_r != SinceMax) since_r <= since_r + 1'b1;
          scan_r <= '0; rv_r <= 1'b0; start_r <= '0; maxi_r <= '0;
          if (!ready_win_r) begin
            fill_r <= fill_r + 1'b1;
            if (fill_r + 1'b1 >= target_r) ready_win_r <= 1'b1;
          end
          if (ready_win_r || (fill_r + 1'b1 >= target_r))
            state_r <= hold_act_r ? S_HOLD : S_RISE;
          else state_r <= S_OLD;
        end
        S_HOLD: begin
          rv_r <= 1'b1;
          if (rv_r) begin
            if ((rdata.n - hold_org_r) > {16'd0, holdoff_r}) hold_act_r <= 1'b0;
            state_r <= S_OLD; rv_r <= 1'b0;
          end
        end
        S_RISE: begin
          rv_r <= scan_r < ScanRiseEnd;
          rd_idx_r <= scan_r[IdxW-1:0];
          scan_r <= scan_r + 1'b1;
          if (rv_r && (excess > $signed({1'b0, rise_r}))) begin
            start_r <= rd_idx_r; base_r <= rdata.b;
            scan_r <= {1'b0, rd_idx_r}; rv_r <= 1'b0;
            state_r <= S_DROP;
          end else if (!rv_r && scan_r >= ScanRiseEnd) begin
            ready_win_r <= 1'b0; fill_r <= '0; target_r <= CntW'(def_refill_r);
            if (since_r >= asys_lim_r && !asys_flag_r) begin
              asys_flag_r <= 1'b1; out_r.asystole_event <= 1'b1;
            end
            state_r <= S_OLD;
          end
        end
        S_DROP: begin
          rv_r <= scan_r < ScanEnd;
          rd_idx_r <= scan_r[IdxW-1:0];
          scan_r <= scan_r + 1'b1;
          if (rv_r && rdata.s < base_r) begin
            finish_r <= rd_idx_r; rv_r <= 1'b0;
            if (len <= {1'b0, wmax_r} && len >= {1'b0, wmin_r}) begin
              scan_r <= {1'b0, start_r}; maxi_r <= start_r; state_r <= S_MAX;
            end else state_r <= S_OLD;
          end else if (!rv_r && scan_r >= ScanEnd) state_r <= S_OLD;
        end
        S_MAX: begin
          // slots start..finish-1, first read seeds the maximum
          rv_r <= 1'b1;
          rd_idx_r <= scan_r[IdxW-1:0];
          scan_r <= scan_r + 1'b1;
          if (rv_r) begin
            if (rd_idx_r == start_r || rdata.s > amp_r) begin
              amp_r <= rdata.s; maxi_r <= rd_idx_r; pn_r <= rdata.n;
            end
            if (rd_idx_r + 1'b1 == finish_r) begin
              rv_r <= 1'b0; state_r <= S_MARK;
              scan_r <= {1'b0, (rdata.s > amp_r) ? rd_idx_r : maxi_r};
            end
          end
        end
        S_MARK: begin
          // read of maxi issued on entry while the height is checked; wait for it, then write mark
          if (!rv_r) begin
            rv_r <= 1'b1;
            if (height > $signed({1'b0, height_r})) state_r <= S_OLD;
          end else begin
            out_r.beat_detected <= 1'b1;
            out_r.rr_interval_ms <= (pn_r - last_pk_r) << 2;
            last_pk_r <= pn_r; since_r <= '0; asys_flag_r <= 1'b0;
            ready_win_r <= 1'b0; fill_r <= '0; target_r <= {1'b0, finish_r};
            hold_org_r <= pn_r; hold_act_r <= 1'b1;
            rv_r <= 1'b0; state_r <= S_OLD;
          end
        end
        S_OLD: begin
          rv_r <= 1'b1;
          if (rv_r) begin
            rv_r <= 1'b0; state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_r.oldest_sample   <= rdata.s;
          out_r.oldest_baseline <= rdata.b;
          out_r.oldest_is_peak  <= rdata.p;
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r) else $error("result dropped");
  a_rr_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.beat_detected) |-> (out_r.rr_interval_ms == '0))
    else $error("rr without beat");
endmodule
`default_nettype wire

// ===== rtl/core/ecgrpw_ram.sv =====
// Generic RAM with one write port and one registered read port
`default_nettype none
module ecgrpw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench: R-peak window detector against a cycle-free beat predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ecgrpw_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ecgrpw_if #(.payload_t(in_item_t))  in_if  (clk);
  ecgrpw_if #(.payload_t(out_item_t)) out_if (clk);
  ecgrpw_if #(.payload_t(cfg_item_t)) cfg_if (clk);

  ecg_r_peak_window_detector i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Register shadows
  logic [31:0] rise_thr = 300;
  logic [31:0] height_lim = 8000;
  logic [31:0] wid_min = 3;
  logic [31:0] wid_max = 30;
  logic [31:0] hold_len = 50;
  logic [31:0] refill_dflt = 32;
  logic [31:0] asys_lim = 1000;

  // Detector state mirror
  logic signed [SampW-1:0] ecg_win [WinSize];
  logic signed [SampW-1:0] base_win [WinSize];
  logic [NumW-1:0]         num_win [WinSize];
  bit                      mark_win [WinSize];
  int          fill_cnt = 0;
  bit          win_rdy = 0;
  int          refill_tgt = 32;
  bit          hold_on = 0;
  logic [31:0] hold_org = '0;
  logic [31:0] last_pk = '0;
  int          since_cnt = 0;
  bit          asys_flag = 0;

  in_item_t  beat_src_q [$];
  out_item_t beat_exp_q [$];
  int        err_cnt = 0;
  bit        idle_on = 1;

  initial begin
    for (int k = 0; k < WinSize; k++) begin
      ecg_win[k] = '0;
      base_win[k] = '0;
      num_win[k] = '0;
      mark_win[k] = 0;
    end
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
  end

  // Shift one sample in and run the window check
  function automatic out_item_t detect_beat(in_item_t it);
    out_item_t r;
    int start, fin, maxi, len;
    logic signed [SampW-1:0] base, amp;
    logic [31:0] diff, pn;
    longint ex;
    r = '0;
    start = -1;
    fin = -1;
    base = '0;
    for (int k = 0; k < WinSize - 1; k++) begin
      ecg_win[k] = ecg_win[k+1];
      base_win[k] = base_win[k+1];
      num_win[k] = num_win[k+1];
      mark_win[k] = mark_win[k+1];
    end
    ecg_win[WinSize-1] = it.ecg_sample;
    base_win[WinSize-1] = it.baseline_value;
    num_win[WinSize-1] = it.sample_number;
    mark_win[WinSize-1] = 0;
    if (!win_rdy) begin
      fill_cnt++;
      if (fill_cnt >= refill_tgt) win_rdy = 1;
    end
    if (since_cnt < 65535) since_cnt++;
    if (win_rdy) begin
      if (hold_on) begin
        diff = num_win[0] - hold_org;
        if (diff > hold_len) hold_on = 0;
      end else begin
        for (int k = 0; k < WinSize - RightMargin; k++) begin
          ex = longint'(ecg_win[k]) - longint'(base_win[k]);
          if (ex > longint'(rise_thr)) begin
            start = k;
            base = base_win[k];
            break;
          end
        end
        if (start < 0) begin
          win_rdy = 0;
          fill_cnt = 0;
          refill_tgt = int'(refill_dflt);
          if (since_cnt >= int'(asys_lim) && !asys_flag) begin
            asys_flag = 1;
            r.asystole_event = 1'b1;
          end
        end else begin
          for (int k = start; k < WinSize; k++) begin
            if (ecg_win[k] < base) begin
              fin = k;
              break;
            end
          end
        end
        if (fin >= 0) begin
          len = fin - start;
          if (len <= int'(wid_max) && len >= int'(wid_min)) begin
            maxi = start;
            amp = ecg_win[start];
            for (int k = start + 1; k < fin; k++) begin
              if (ecg_win[k] > amp) begin
                amp = ecg_win[k];
                maxi = k;
              end
            end
            if (longint'(amp) - longint'(base) <= longint'(height_lim)) begin
              pn = num_win[maxi];
              mark_win[maxi] = 1;
              r.rr_interval_ms = (pn - last_pk) << 2;
              r.beat_detected = 1'b1;
              last_pk = pn;
              since_cnt = 0;
              asys_flag = 0;
              win_rdy = 0;
              fill_cnt = 0;
              refill_tgt = fin;
              hold_org = pn;
              hold_on = 1;
            end
          end
        end
      end
    end
    r.oldest_sample = ecg_win[0];
    r.oldest_baseline = base_win[0];
    r.oldest_is_peak = mark_win[0];
    return r;
  endfunction

  // Sample driver with random idle bursts
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) beat_exp_q.push_back(detect_beat(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (beat_src_q.size() > 0) begin
          in_if.data <= beat_src_q.pop_front();
          in_if.valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 4);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stall bursts
  int snk_stall = 0;
  always @(posedge clk) begin
    out_item_t e, g;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      snk_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        g = out_if.data;
        if (beat_exp_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, g);
          err_cnt++;
        end else begin
          e = beat_exp_q.pop_front();
          if (g.oldest_sample !== e.oldest_sample)
            $display("%0t: oldest_sample exp %0d act %0d", $time, e.oldest_sample,
                     g.oldest_sample);
          if (g.oldest_baseline !== e.oldest_baseline)
            $display("%0t: oldest_baseline exp %0d act %0d", $time, e.oldest_baseline,
                     g.oldest_baseline);
          if (g.oldest_is_peak !== e.oldest_is_peak)
            $display("%0t: oldest_is_peak exp %0b act %0b", $time, e.oldest_is_peak,
                     g.oldest_is_peak);
          if (g.beat_detected !== e.beat_detected)
            $display("%0t: beat_detected exp %0b act %0b", $time, e.beat_detected,
                     g.beat_detected);
          if (g.rr_interval_ms !== e.rr_interval_ms)
            $display("%0t: rr_interval_ms exp %0d act %0d", $time, e.rr_interval_ms,
                     g.rr_interval_ms);
          if (g.asystole_event !== e.asystole_event)
            $display("%0t: asystole_event exp %0b act %0b", $time, e.asystole_event,
                     g.asystole_event);
          if (g !== e) err_cnt++;
        end
      end
      if (snk_stall > 0) begin
        snk_stall <= snk_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) snk_stall <= $urandom_range(1, 4);
      end
    end
  end

  // Register write; only called while the detector is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_if.data <= '{index: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      RegRise:     rise_thr = val & 32'hFF_FFFF;
      RegHeight:   height_lim = val & 32'hFF_FFFF;
      RegWidthMin: wid_min = val & 32'h3F;
      RegWidthMax: wid_max = val & 32'h3F;
      RegHoldoff:  hold_len = val & 32'hFFFF;
      RegRefill:   refill_dflt = val & 32'h7F;
      RegAsys:     asys_lim = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  // Let every result arrive, then idle on to catch any unexpected result
  task automatic drain();
    while (beat_src_q.size() != 0 || in_if.valid || beat_exp_q.size() != 0)
      @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  function automatic logic signed [SampW-1:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[SampW-1:0];
  endfunction

  logic [31:0] snum = 0;
  longint      drift = 0;

  function automatic void push_smp(longint s);
    in_item_t it;
    drift = drift + $signed($urandom_range(0, 40)) - 20;
    if (drift > 4000 || drift < -4000) drift = 0;
    it.ecg_sample = clamp24(s + drift);
    it.baseline_value = clamp24(drift);
    if ($urandom_range(0, 99) == 0) snum = $urandom;
    else snum = snum + 1;
    it.sample_number = snum;
    beat_src_q.push_back(it);
  endfunction

  function automatic void push_noise(int n);
    longint amp;
    amp = (rise_thr / 2 > 2000) ? 2000 : rise_thr / 2;
    repeat (n) push_smp(longint'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // Mix of beat-shaped pulses, noise stretches and raw random items
  task automatic gen_items(int n);
    int cnt, w, sel;
    longint lo, top;
    in_item_t it;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        it.ecg_sample = SampW'($urandom);
        it.baseline_value = SampW'($urandom);
        it.sample_number = $urandom;
        beat_src_q.push_back(it);
        cnt++;
      end else if (sel == 1) begin
        w = $urandom_range(20, 60);
        push_noise(w);
        cnt += w;
      end else begin
        w = $urandom_range(1, 36);
        lo = longint'(rise_thr) + 1;
        top = ($urandom_range(0, 5) == 0) ? longint'(height_lim) + 1000 : lo + 3000;
        push_noise($urandom_range(3, 25));
        repeat (w) push_smp(lo + $urandom_range(0, int'(top - lo)));
        push_smp(-longint'($urandom_range(1, 300)));
        push_noise($urandom_range(3, 20));
        cnt += w + 30;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and a clean beat under reset settings
    it = '{ecg_sample: 24'sh7FFFFF, baseline_value: 24'sh800000, sample_number: 32'h0};
    beat_src_q.push_back(it);
    it = '{ecg_sample: 24'sh800000, baseline_value: 24'sh7FFFFF, sample_number: '1};
    beat_src_q.push_back(it);
    it = '{ecg_sample: '0, baseline_value: '0, sample_number: 32'h8000_0000};
    beat_src_q.push_back(it);
    snum = 32'hFFFF_FFF8;
    push_noise(6);
    repeat (5) push_smp(1500);
    push_smp(-100);
    push_noise(8);
    drain();

    gen_items(220);
    drain();

    // Loosest settings
    write_reg(RegRise, 0);
    write_reg(RegHeight, 32'hFF_FFFF);
    write_reg(RegWidthMin, 0);
    write_reg(RegWidthMax, 63);
    write_reg(RegHoldoff, 0);
    write_reg(RegRefill, 1);
    write_reg(RegAsys, 0);
    gen_items(130);
    drain();

    // Tightest settings: nothing rises
    write_reg(RegRise, 32'hFF_FFFF);
    write_reg(RegHeight, 0);
    write_reg(RegWidthMin, 63);
    write_reg(RegWidthMax, 0);
    write_reg(RegHoldoff, 32'hFFFF);
    write_reg(RegRefill, 64);
    write_reg(RegAsys, 32'hFFFF);
    gen_items(80);
    drain();

    // Mid settings, short asystole limit; final stretch with no idling
    write_reg(RegRise, 500);
    write_reg(RegHeight, 20000);
    write_reg(RegWidthMin, 2);
    write_reg(RegWidthMax, 40);
    write_reg(RegHoldoff, 20);
    write_reg(RegRefill, 16);
    write_reg(RegAsys, 100);
    gen_items(120);
    drain();
    idle_on = 0;
    gen_items(80);
    drain();

    if (err_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
